// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the LED fade color sequencer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is asserted.
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs, off while reset is asserted.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/lfcs_pkg.sv
// Package of the LED fade color sequencer: widths, codes, reset values, types.
// Depends on nothing; used by lfcs_div and led_fade_color_sequencer_top.
`default_nettype none

package lfcs_pkg;

	// Field and register widths
	localparam int TIME_W        = 32;
	localparam int DUR_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int DUTY_BITS_DEF = 10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFF_DURATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 2'd1;

	// Register reset values
	localparam logic [DUR_W-1:0] OFF_DURATION_RST  = 16'd500;
	localparam logic [DUR_W-1:0] FADE_DURATION_RST = 16'd1000;

	// Phase codes
	localparam logic [1:0] PH_OFF  = 2'd0;
	localparam logic [1:0] PH_IN   = 2'd1;
	localparam logic [1:0] PH_OUT  = 2'd2;
	localparam logic [1:0] PH_RSVD = 2'd3;

	// Color codes
	localparam logic [1:0] COL_GREEN  = 2'd0;
	localparam logic [1:0] COL_RED    = 2'd1;
	localparam logic [1:0] COL_ORANGE = 2'd2;
	localparam logic [1:0] COL_RSVD   = 2'd3;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} lfcs_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/lfcs_div.sv
// Restoring divider for the fade ramp: quotient of e*FULL by the fade duration.
// Depends on lfcs_pkg; one quotient bit per cycle, DUTY_BITS quotient bits per divide.
`default_nettype none

module lfcs_div
	import lfcs_pkg::*;
#(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DUR_W+DUTY_BITS-1:0] num,
	input  wire logic [DUR_W-1:0]           den,
	output lfcs_div_stat_t                  stat,
	output logic [DUTY_BITS-1:0]            quo
);

	localparam int CNT_W = $clog2(DUTY_BITS + 1);

	logic [DUR_W-1:0]     rem_q;
	logic [DUTY_BITS-1:0] low_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DUR_W:0]       trial;
	logic                 fits;

	// Shift in the next numerator bit and test against the divisor
	assign trial = {rem_q, low_q[DUTY_BITS-1]};
	assign fits  = trial >= {1'b0, den};

	// Control: iteration count, busy and a done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DUTY_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the high numerator part is below the divisor, so only
	// DUTY_BITS quotient bits are produced
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DUR_W+DUTY_BITS-1:DUTY_BITS];
			low_q <= num[DUTY_BITS-1:0];
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DUR_W'(trial - {1'b0, den});
			end else begin
				rem_q <= trial[DUR_W-1:0];
			end
			low_q <= {low_q[DUTY_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = low_q;

endmodule

`default_nettype wire

// File: rtl/led_fade_color_sequencer_top.sv
// Top level of the LED fade color sequencer: sequencer, state and output register.
// Depends on lfcs_pkg, lfcs_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Each now_ms beat yields one green/red duty beat. A beat in a fade phase with
// a nonzero fade duration passes from acceptance through ST_START, ST_DIV and
// ST_LOAD to the result register, waiting in ST_DIV for the restoring divider,
// which produces one quotient bit per cycle; an off-phase or zero-fade beat goes
// from ST_START straight to ST_LOAD. in_ready is low while a beat is being
// worked on and returns once its result is loaded; a loaded result waits in the
// output register while the next beat is accepted. cfg_ready is always high.
module led_fade_color_sequencer_top
	import lfcs_pkg::*;
#(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DUR_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [TIME_W-1:0]    now_ms,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [DUTY_BITS-1:0]      green_duty,
	output logic [DUTY_BITS-1:0]      red_duty
);

	localparam int                   NUM_W = DUR_W + DUTY_BITS;
	localparam logic [DUTY_BITS-1:0] FULL  = {DUTY_BITS{1'b1}};

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	logic [1:0]           state_q;
	logic [DUR_W-1:0]     off_q;
	logic [DUR_W-1:0]     fade_q;
	logic [1:0]           phase_q;
	logic [1:0]           color_q;
	logic [TIME_W-1:0]    start_time_q;

	logic [DUR_W-1:0]     e_q;
	logic                 lit_q;
	logic                 inv_q;
	logic [1:0]           sel_q;
	logic [DUTY_BITS-1:0] ramp_q;

	logic                 out_valid_q;
	logic [DUTY_BITS-1:0] green_q;
	logic [DUTY_BITS-1:0] red_q;

	logic [TIME_W-1:0]    elapsed;
	logic                 fade_over;
	logic                 off_over;
	logic [DUR_W-1:0]     e_clamp;
	logic                 accept;
	logic                 div_start;
	logic [NUM_W-1:0]     div_num;
	lfcs_div_stat_t       div_stat;
	logic [DUTY_BITS-1:0] div_quo;
	logic [DUTY_BITS-1:0] duty;
	logic                 out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Elapsed time since the phase start, wrapping, and its clamp to the ramp
	assign elapsed   = now_ms - start_time_q;
	assign fade_over = elapsed >= {{(TIME_W-DUR_W){1'b0}}, fade_q};
	assign off_over  = elapsed >= {{(TIME_W-DUR_W){1'b0}}, off_q};
	assign e_clamp   = fade_over ? fade_q : elapsed[DUR_W-1:0];

	// Configuration registers; other indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= OFF_DURATION_RST;
			fade_q <= FADE_DURATION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFF_DURATION:  off_q  <= cfg_data;
				REG_FADE_DURATION: fade_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Advance phase, color and phase start on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OFF;
			color_q      <= COL_GREEN;
			start_time_q <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_IN: begin
					if (fade_over) begin
						phase_q      <= PH_OUT;
						start_time_q <= now_ms;
					end
				end
				PH_OUT: begin
					if (fade_over) begin
						phase_q      <= PH_OFF;
						start_time_q <= now_ms;
						case (color_q)
							COL_GREEN: color_q <= COL_RED;
							COL_RED:   color_q <= COL_ORANGE;
							COL_RSVD:  color_q <= COL_RED;
							default:   color_q <= COL_GREEN;
						endcase
					end
				end
				default: begin
					if (off_over) begin
						phase_q      <= PH_IN;
						start_time_q <= now_ms;
					end
				end
			endcase
		end
	end

	// Hold what the beat needs for its duty, taken before the phase moves
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= e_clamp;
			lit_q <= (phase_q == PH_IN) || (phase_q == PH_OUT);
			inv_q <= phase_q == PH_OUT;
			sel_q <= color_q;
		end
	end

	// Sequencer: start the divide, collect the ramp, load the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_START;
				ST_START: state_q <= div_start ? ST_DIV : ST_LOAD;
				ST_DIV:   if (div_stat.done) state_q <= ST_LOAD;
				ST_LOAD:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Ramp value: full at once for a zero fade duration, else the quotient
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			ramp_q <= FULL;
		end else if (state_q == ST_DIV && div_stat.done) begin
			ramp_q <= div_quo;
		end
	end

	assign div_start = (state_q == ST_START) && lit_q && (fade_q != '0);

	// e*FULL as a shift and subtract
	assign div_num = {e_q, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, e_q};

	lfcs_div #(
		.DUTY_BITS(DUTY_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (fade_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// Fade-out mirrors the ramp; dark when not lit
	assign duty = !lit_q ? '0 : (inv_q ? FULL - ramp_q : ramp_q);

	// Output register: load on a free slot, drop the valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LOAD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && out_free) begin
			green_q <= (sel_q == COL_RED) ? '0 : duty;
			red_q   <= (sel_q == COL_GREEN) ? '0 : duty;
		end
	end

	assign out_valid  = out_valid_q;
	assign green_duty = green_q;
	assign red_duty   = red_q;

	// Checks on the sequencer
	`AST_HOLDS(a_busy_after_accept, clk, arst_n, accept |=> !in_ready, "ready after accept")
	`AST_HOLDS(a_done_in_div, clk, arst_n, div_stat.done |-> state_q == ST_DIV, "stray done")
	`AST_HOLDS(a_idle_div_free, clk, arst_n, state_q == ST_IDLE |-> !div_stat.busy, "div busy")
	`AST_HOLDS(a_load_src, clk, arst_n, $rose(out_valid_q) |-> $past(state_q) == ST_LOAD, "bad load")
	`AST_NEVER(a_phase_code, clk, arst_n, phase_q == PH_RSVD || color_q == COL_RSVD, "bad code")

endmodule

`default_nettype wire
